### hdl/spa_pkg.sv
package spa_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [1:0] OP_RUN         = 2'd2;

   // A run never delivers more result words than this.
   localparam int unsigned RESULT_CAP = 32;
   localparam int unsigned RESULT_CW  = $clog2(RESULT_CAP + 1);

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] coef;
      logic [15:0]        exp;
   } req_type;

   typedef struct packed {
      logic signed [16:0] sum_coef;
      logic [15:0]        sum_exp;
      logic               last;
      logic               empty_res;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] coef;
      logic [15:0]        exp;
   } term_type;

endpackage

### hdl/spa_term_store.sv
module spa_term_store #(
   parameter int unsigned AW    = 4,
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  spa_pkg::term_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output spa_pkg::term_type rd_data
);

   spa_pkg::term_type term_mem_ff [DEPTH];
   spa_pkg::term_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         term_mem_ff[wr_addr] <= wr_data;
      end
   end

   // The read port runs every cycle; the merge engine steers the address with the
   // next index so that the head term is ready when it is needed.
   always_ff @(posedge clock) begin
      rd_data_ff <= term_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/spa_merge.sv
module spa_merge #(
   parameter int unsigned MAX_TERMS = 16,
   parameter int unsigned AW        = 4,
   parameter int unsigned CW        = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spa_pkg::req_type  req_data,
   output logic              busy,
   output logic              rsp_valid,
   output spa_pkg::rsp_type  rsp_data,
   output logic              fst_wr_en,
   output logic [AW-1:0]     fst_wr_addr,
   output logic              snd_wr_en,
   output logic [AW-1:0]     snd_wr_addr,
   output spa_pkg::term_type wr_data,
   output logic [AW-1:0]     fst_rd_addr,
   output logic [AW-1:0]     snd_rd_addr,
   input  spa_pkg::term_type fst_rd_data,
   input  spa_pkg::term_type snd_rd_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam int unsigned NW = spa_pkg::RESULT_CW;

   logic             state_ff,      state_in;
   logic [CW-1:0]    fst_count_ff,  fst_count_in;
   logic [CW-1:0]    snd_count_ff,  snd_count_in;
   logic [CW-1:0]    i_ff,          i_in;
   logic [CW-1:0]    j_ff,          j_in;
   logic [NW-1:0]    n_ff,          n_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   spa_pkg::rsp_type rsp_data_ff,   rsp_data_in;

   logic accept;
   logic fst_ok;
   logic snd_ok;

   assign busy   = (state_ff == ST_RUN);
   assign accept = start && !busy;
   assign fst_ok = (i_ff < fst_count_ff);
   assign snd_ok = (j_ff < snd_count_ff);

   assign wr_data.coef = req_data.coef;
   assign wr_data.exp  = req_data.exp;
   assign fst_wr_addr  = fst_count_ff[AW-1:0];
   assign snd_wr_addr  = snd_count_ff[AW-1:0];

   // Read addresses follow the next indexes, so the stores present the new
   // heads in the cycle after each merge step.
   assign fst_rd_addr = i_in[AW-1:0];
   assign snd_rd_addr = j_in[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      fst_count_in = fst_count_ff;
      snd_count_in = snd_count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      fst_wr_en    = 1'b0;
      snd_wr_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            n_in = '0;
            if (accept) begin
               unique case (req_data.op)
                  spa_pkg::OP_LOAD_FIRST: begin
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.last = 1'b1;
                     if (fst_count_ff == CW'(MAX_TERMS)) begin
                        rsp_data_in.overflow = 1'b1;
                     end else begin
                        fst_wr_en    = 1'b1;
                        fst_count_in = fst_count_ff + CW'(1);
                     end
                  end
                  spa_pkg::OP_LOAD_SECOND: begin
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.last = 1'b1;
                     if (snd_count_ff == CW'(MAX_TERMS)) begin
                        rsp_data_in.overflow = 1'b1;
                     end else begin
                        snd_wr_en    = 1'b1;
                        snd_count_in = snd_count_ff + CW'(1);
                     end
                  end
                  spa_pkg::OP_RUN: begin
                     if (fst_count_ff == '0 && snd_count_ff == '0) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.last      = 1'b1;
                        rsp_data_in.empty_res = 1'b1;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            rsp_valid_in = 1'b1;
            if (fst_ok && snd_ok && fst_rd_data.exp == snd_rd_data.exp) begin
               rsp_data_in.sum_coef = {fst_rd_data.coef[15], fst_rd_data.coef}
                                    + {snd_rd_data.coef[15], snd_rd_data.coef};
               rsp_data_in.sum_exp  = fst_rd_data.exp;
               i_in = i_ff + CW'(1);
               j_in = j_ff + CW'(1);
            end else if (!snd_ok || (fst_ok && fst_rd_data.exp > snd_rd_data.exp)) begin
               rsp_data_in.sum_coef = {fst_rd_data.coef[15], fst_rd_data.coef};
               rsp_data_in.sum_exp  = fst_rd_data.exp;
               i_in = i_ff + CW'(1);
            end else begin
               rsp_data_in.sum_coef = {snd_rd_data.coef[15], snd_rd_data.coef};
               rsp_data_in.sum_exp  = snd_rd_data.exp;
               j_in = j_ff + CW'(1);
            end
            n_in = n_ff + NW'(1);
            if (!((i_in < fst_count_ff) || (j_in < snd_count_ff)) ||
                n_in == NW'(spa_pkg::RESULT_CAP)) begin
               rsp_data_in.last = 1'b1;
               state_in         = ST_IDLE;
               fst_count_in     = '0;
               snd_count_in     = '0;
               i_in             = '0;
               j_in             = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fst_count_ff <= '0;
         snd_count_ff <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fst_count_ff <= fst_count_in;
         snd_count_ff <= snd_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/sparse_polynomial_adder.sv
// Channel    Ports                         Direction  Handshake
// request    start, busy, req_data         in         taken when start is high, busy low
// response   rsp_valid, rsp_data           out        one-cycle strobe, cannot be held off
//
// A load is acknowledged in the next cycle; an unused opcode returns nothing.
// A new word may follow in the next cycle. A run of two empty stores answers
// with its empty word in the next cycle. Any other run keeps busy high for one
// merged term per cycle, at most 2 * MAX_TERMS and never above 32, paced by the
// single read port of each store; the last term appears in the cycle busy falls.
// Reset is synchronous and empties both stores.
module sparse_polynomial_adder #(
   parameter int unsigned MAX_TERMS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  spa_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output spa_pkg::rsp_type rsp_data
);

   localparam int unsigned AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned CW    = $clog2(MAX_TERMS + 1);

   logic              fst_wr_en;
   logic [AW-1:0]     fst_wr_addr;
   logic              snd_wr_en;
   logic [AW-1:0]     snd_wr_addr;
   spa_pkg::term_type wr_data;
   logic [AW-1:0]     fst_rd_addr;
   logic [AW-1:0]     snd_rd_addr;
   spa_pkg::term_type fst_rd_data;
   spa_pkg::term_type snd_rd_data;

   spa_term_store #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_fst_store (
      .clock   (clock),
      .wr_en   (fst_wr_en),
      .wr_addr (fst_wr_addr),
      .wr_data (wr_data),
      .rd_addr (fst_rd_addr),
      .rd_data (fst_rd_data)
   );

   spa_term_store #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_snd_store (
      .clock   (clock),
      .wr_en   (snd_wr_en),
      .wr_addr (snd_wr_addr),
      .wr_data (wr_data),
      .rd_addr (snd_rd_addr),
      .rd_data (snd_rd_data)
   );

   spa_merge #(
      .MAX_TERMS (MAX_TERMS),
      .AW        (AW),
      .CW        (CW)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fst_wr_en   (fst_wr_en),
      .fst_wr_addr (fst_wr_addr),
      .snd_wr_en   (snd_wr_en),
      .snd_wr_addr (snd_wr_addr),
      .wr_data     (wr_data),
      .fst_rd_addr (fst_rd_addr),
      .snd_rd_addr (snd_rd_addr),
      .fst_rd_data (fst_rd_data),
      .snd_rd_data (snd_rd_data)
   );

`ifndef SYNTHESIS
   // Every cycle of a run yields exactly one merged word.
   a_run_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("run cycle without a result word");

   // A load is acknowledged in the next cycle with a final word.
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == spa_pkg::OP_LOAD_FIRST ||
                          req_data.op == spa_pkg::OP_LOAD_SECOND))
      |=> (rsp_valid && rsp_data.last && !rsp_data.empty_res))
      else $error("load not acknowledged");

   // Stores are written only outside a run, and never both at once.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (fst_wr_en || snd_wr_en) |-> (!busy && !(fst_wr_en && snd_wr_en)))
      else $error("store write during a run");

   // An empty-sum word is always final and carries no overflow.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_res) |-> (rsp_data.last && !rsp_data.overflow))
      else $error("malformed empty result");
`endif

endmodule
